@@ hw/rtl/vdm_pkg.sv @@
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared types and constants for the vector distance metric unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vdm_pkg;

    localparam int COORD_W   = 16;
    localparam int DIST_W    = 58;
    localparam int FRAC_W    = 16;
    // Accumulator widths cover up to 65536 pairs of 16-bit coordinates.
    localparam int DSUM_W    = 49;
    localparam int SQ_W      = 47;
    localparam int DOT_W     = 48;
    localparam int PROD_W    = 2 * SQ_W;
    localparam int ROOT_W    = PROD_W / 2;
    localparam int NUM_W     = SQ_W + FRAC_W;
    localparam int MAX_ELEMS_DEFAULT = 1024;
    localparam logic [FRAC_W:0] ONE_FX = 17'h10000;

    typedef enum logic [2:0] {
        M_EUCLID   = 3'd0,
        M_SQUARED  = 3'd1,
        M_CITY     = 3'd2,
        M_CHEBY    = 3'd3,
        M_COSINE   = 3'd4,
        M_HAMMING  = 3'd5,
        M_JACCARD  = 3'd6,
        M_UNUSED   = 3'd7
    } t_metric;

    typedef enum logic [2:0] {
        S_ACC, S_DRAIN, S_LAUNCH, S_MUL, S_SQRT, S_DIV, S_RES
    } t_vdm_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic                      last_pair;
    } t_vdm_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              length_overflow;
    } t_vdm_out;

    typedef struct packed {
        logic accept;
        logic mul_start;
        logic sqrt_start;
        logic div_start;
        logic load_out;
    } t_vdm_cmd;

    typedef struct packed {
        t_metric metric;
        logic    cos_zero;
        logic    mul_done;
        logic    sqrt_done;
        logic    div_done;
        logic    out_free;
    } t_vdm_status;

endpackage

`default_nettype wire

@@ hw/rtl/vdm_isqrt.sv @@
// ----------------------------------------------------------------------------
// vdm_isqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_isqrt import vdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_radicand,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int CW = $clog2(ROOT_W);

    logic [PROD_W-1:0] r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+1:0] n_trem;
    logic [ROOT_W+1:0] n_trial;

    assign n_trem  = {r_rem[ROOT_W-1:0], r_rad[PROD_W-1 -: 2]};
    assign n_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[PROD_W-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (n_trem >= n_trial) begin
                r_rem  <= n_trem - n_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_trem;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ hw/rtl/vdm_div.sv @@
// ----------------------------------------------------------------------------
// vdm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_div import vdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [ROOT_W-1:0] i_den,
    output logic                   o_done,
    output logic [NUM_W-1:0]       o_quot
);

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0]  r_q;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W:0]   n_trem;

    assign n_trem = {r_rem[ROOT_W-1:0], r_q[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The quotient bits shift in behind the numerator bits as they are used.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (n_trem >= {1'b0, r_den}) begin
                r_rem <= n_trem - {1'b0, r_den};
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trem;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ hw/rtl/vdm_datapath.sv @@
// ----------------------------------------------------------------------------
// vdm_datapath
// Product stage, accumulators, serial multiplier, root and divide units,
// result formatting and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_datapath import vdm_pkg::*; #(
    parameter int MAX_ELEMS = MAX_ELEMS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_vdm_cmd    i_cmd,
    output t_vdm_status      o_status,
    input  wire t_vdm_in     i_in,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_vdm_out         o_out
);

    localparam int CNT_W = $clog2(MAX_ELEMS + 2);
    localparam int MCW   = $clog2(SQ_W);

    t_metric r_metric;

    // Product stage.
    logic              r_p_valid;
    logic [31:0]       r_p_dterm;
    logic [15:0]       r_p_ad;
    logic signed [31:0] r_p_prod;
    logic [31:0]       r_p_asq;
    logic [31:0]       r_p_bsq;
    logic              r_p_mis;
    logic              r_p_nz;

    // Accumulators.
    logic [DSUM_W-1:0] r_dsum;
    logic [DOT_W-1:0]  r_dot;
    logic [SQ_W-1:0]   r_asq;
    logic [SQ_W-1:0]   r_bsq;
    logic [15:0]       r_maxd;
    logic [CNT_W-1:0]  r_mis;
    logic [CNT_W-1:0]  r_nz;
    logic [CNT_W-1:0]  r_pairs;

    // Serial multiplier.
    logic [PROD_W-1:0] r_m_acc;
    logic [PROD_W-1:0] r_m_cand;
    logic [SQ_W-1:0]   r_m_plier;
    logic [MCW-1:0]    r_m_cnt;
    logic              r_m_busy;
    logic              r_m_done;

    logic              r_out_valid;
    t_vdm_out          r_out;

    logic signed [16:0] n_diff;
    logic [16:0]        n_ad;
    logic [16:0]        n_aa;
    logic [16:0]        n_ab;
    logic               n_xa;
    logic               n_xb;
    logic [PROD_W-1:0]  n_rad;
    logic [ROOT_W-1:0]  n_root;
    logic               n_sqrt_done;
    logic [NUM_W-1:0]   n_num;
    logic [ROOT_W-1:0]  n_den;
    logic [NUM_W-1:0]   n_quot;
    logic               n_div_done;
    logic [DOT_W-1:0]   n_dot_abs;
    logic [FRAC_W:0]    n_qc;
    logic [CNT_W-1:0]   n_n;
    logic [DIST_W-1:0]  n_dist;
    logic               n_out_free;

    always_comb begin
        n_diff = {i_in.coord_a[COORD_W-1], i_in.coord_a}
               - {i_in.coord_b[COORD_W-1], i_in.coord_b};
        n_ad   = n_diff[16] ? 17'(-n_diff) : 17'(n_diff);
        n_aa   = i_in.coord_a[COORD_W-1] ? 17'(-{1'b1, i_in.coord_a})
                                         : {1'b0, i_in.coord_a};
        n_ab   = i_in.coord_b[COORD_W-1] ? 17'(-{1'b1, i_in.coord_b})
                                         : {1'b0, i_in.coord_b};
        n_xa   = i_in.coord_a != '0;
        n_xb   = i_in.coord_b != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= M_EUCLID;
        end else if (i_cfg_we) begin
            r_metric <= t_metric'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.accept && (r_pairs < CNT_W'(MAX_ELEMS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_ad    <= n_ad[15:0];
            r_p_dterm <= (r_metric == M_CITY) ? {16'b0, n_ad[15:0]}
                                              : n_ad[15:0] * n_ad[15:0];
            r_p_prod  <= i_in.coord_a * i_in.coord_b;
            r_p_asq   <= n_aa[15:0] * n_aa[15:0];
            r_p_bsq   <= n_ab[15:0] * n_ab[15:0];
            if (r_metric == M_JACCARD) begin
                r_p_mis <= n_xa != n_xb;
                r_p_nz  <= n_xa || n_xb;
            end else begin
                r_p_mis <= i_in.coord_a != i_in.coord_b;
                r_p_nz  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_dsum  <= '0;
            r_dot   <= '0;
            r_asq   <= '0;
            r_bsq   <= '0;
            r_maxd  <= '0;
            r_mis   <= '0;
            r_nz    <= '0;
            r_pairs <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (r_pairs < CNT_W'(MAX_ELEMS)) begin
                    r_pairs <= r_pairs + 1'b1;
                end else begin
                    r_pairs <= CNT_W'(MAX_ELEMS + 1);
                end
            end
            if (r_p_valid) begin
                r_dsum <= r_dsum + DSUM_W'(r_p_dterm);
                r_dot  <= r_dot + {{(DOT_W-32){r_p_prod[31]}}, r_p_prod};
                r_asq  <= r_asq + SQ_W'(r_p_asq);
                r_bsq  <= r_bsq + SQ_W'(r_p_bsq);
                if (r_p_ad > r_maxd) begin
                    r_maxd <= r_p_ad;
                end
                r_mis <= r_mis + CNT_W'(r_p_mis);
                r_nz  <= r_nz + CNT_W'(r_p_nz);
            end
        end
    end

    // Shift-and-add product of the two square sums for the cosine norm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_busy <= 1'b0;
            r_m_done <= 1'b0;
        end else begin
            r_m_done <= 1'b0;
            if (i_cmd.mul_start) begin
                r_m_busy <= 1'b1;
            end else if (r_m_busy && r_m_cnt == MCW'(SQ_W - 1)) begin
                r_m_busy <= 1'b0;
                r_m_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_m_acc   <= '0;
            r_m_cand  <= PROD_W'(r_asq);
            r_m_plier <= r_bsq;
            r_m_cnt   <= '0;
        end else if (r_m_busy) begin
            if (r_m_plier[0]) begin
                r_m_acc <= r_m_acc + r_m_cand;
            end
            r_m_cand  <= {r_m_cand[PROD_W-2:0], 1'b0};
            r_m_plier <= {1'b0, r_m_plier[SQ_W-1:1]};
            r_m_cnt   <= r_m_cnt + 1'b1;
        end
    end

    assign n_rad = (r_metric == M_COSINE) ? r_m_acc
                                          : PROD_W'({r_dsum, 32'b0});

    vdm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (n_rad),
        .o_done     (n_sqrt_done),
        .o_root     (n_root)
    );

    assign n_dot_abs = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : r_dot;

    always_comb begin
        case (r_metric)
            M_COSINE: begin
                n_num = {n_dot_abs[SQ_W-1:0], 16'b0};
                n_den = n_root;
            end
            M_JACCARD: begin
                n_num = NUM_W'({r_mis, 16'b0});
                n_den = ROOT_W'(r_nz);
            end
            default: begin
                n_num = NUM_W'({r_mis, 16'b0});
                n_den = ROOT_W'(n_n);
            end
        endcase
    end

    vdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    assign n_n  = (r_pairs > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : r_pairs;
    assign n_qc = (n_quot > NUM_W'(ONE_FX)) ? ONE_FX : n_quot[FRAC_W:0];

    always_comb begin
        case (r_metric)
            M_EUCLID: n_dist = DIST_W'(n_root);
            M_SQUARED, M_CITY: begin
                if (r_dsum > DSUM_W'({(DIST_W-FRAC_W){1'b1}})) begin
                    n_dist = '1;
                end else begin
                    n_dist = DIST_W'({r_dsum, 16'b0});
                end
            end
            M_CHEBY: n_dist = DIST_W'({r_maxd, 16'b0});
            M_COSINE: begin
                if (r_asq == '0 || r_bsq == '0) begin
                    n_dist = DIST_W'(ONE_FX);
                end else if (r_dot[DOT_W-1]) begin
                    n_dist = DIST_W'(ONE_FX) + DIST_W'(n_qc);
                end else begin
                    n_dist = DIST_W'(ONE_FX) - DIST_W'(n_qc);
                end
            end
            M_HAMMING: n_dist = (n_n == '0) ? '0 : DIST_W'(n_quot);
            M_JACCARD: n_dist = (r_nz == '0) ? '0 : DIST_W'(n_quot);
            default:   n_dist = '0;
        endcase
    end

    assign n_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.distance        <= n_dist;
            r_out.length_overflow <= r_pairs > CNT_W'(MAX_ELEMS);
        end
    end

    assign o_status.metric    = r_metric;
    assign o_status.cos_zero  = (r_asq == '0) || (r_bsq == '0);
    assign o_status.mul_done  = r_m_done;
    assign o_status.sqrt_done = n_sqrt_done;
    assign o_status.div_done  = n_div_done;
    assign o_status.out_free  = n_out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/vdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// vdm_ctrl
// Sequencer: accumulate phase, then the finishing steps of the chosen metric.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_ctrl import vdm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_last_pair,
    output logic             o_in_stall,
    input  wire t_vdm_status i_status,
    output t_vdm_cmd         o_cmd
);

    t_vdm_state r_state;
    t_vdm_state n_state;
    logic       n_accept;

    assign n_accept = i_in_valid && (r_state == S_ACC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC:    if (n_accept && i_last_pair) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_LAUNCH;
            S_LAUNCH: begin
                case (i_status.metric)
                    M_EUCLID:             n_state = S_SQRT;
                    M_COSINE:             n_state = i_status.cos_zero ? S_RES : S_MUL;
                    M_HAMMING, M_JACCARD: n_state = S_DIV;
                    default:              n_state = S_RES;
                endcase
            end
            S_MUL:    if (i_status.mul_done) n_state = S_SQRT;
            S_SQRT: begin
                if (i_status.sqrt_done) begin
                    n_state = (i_status.metric == M_COSINE) ? S_DIV : S_RES;
                end
            end
            S_DIV:    if (i_status.div_done) n_state = S_RES;
            S_RES:    if (i_status.out_free) n_state = S_ACC;
            default:  n_state = S_ACC;
        endcase
    end

    always_comb begin
        o_in_stall       = r_state != S_ACC;
        o_cmd.accept     = n_accept;
        o_cmd.mul_start  = (r_state == S_LAUNCH) && (i_status.metric == M_COSINE)
                         && !i_status.cos_zero;
        o_cmd.sqrt_start = ((r_state == S_LAUNCH) && (i_status.metric == M_EUCLID))
                         || ((r_state == S_MUL) && i_status.mul_done);
        o_cmd.div_start  = ((r_state == S_LAUNCH)
                            && (i_status.metric == M_HAMMING
                                || i_status.metric == M_JACCARD))
                         || ((r_state == S_SQRT) && i_status.sqrt_done
                             && (i_status.metric == M_COSINE));
        o_cmd.load_out   = (r_state == S_RES) && i_status.out_free;
    end

endmodule

`default_nettype wire

@@ hw/rtl/vector_distance_metric_unit_top.sv @@
// ----------------------------------------------------------------------------
// vector_distance_metric_unit_top
// Distance between two vectors streamed one coordinate pair per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one pair of matching signed coordinates and a flag
// on the last pair. Pairs are taken one per cycle while the vector streams in;
// a two-stage product/accumulate path keeps the running sums.
// After the last pair the block stalls its input while it finishes: a drain
// state and a launch state, then the metric's iterative work: the square root,
// the divider, and for cosine a serial multiply before both.
// The next pair can be taken in the cycle after the result is loaded.
// The result beat sits in an output register. A stalled receiver holds it
// there, and the block goes back to taking pairs; it stalls again only if the
// next result is ready while the previous one is still waiting.
// Reset (synchronous, active low) selects the Euclidean metric, clears all
// accumulators and empties the output register.
// The metric register is written through its own valid/ready port, which is
// always ready; it is meant to change only while the block is idle.
// Pairs beyond MAX_ELEMS are not accumulated; they set the length overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_distance_metric_unit_top import vdm_pkg::*; #(
    parameter int MAX_ELEMS = MAX_ELEMS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_vdm_in    i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_vdm_out        o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);

    t_vdm_cmd    w_cmd;
    t_vdm_status w_status;

    // The metric register can always take a write.
    assign o_cfg_ready = 1'b1;

    vdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pair (i_in.last_pair),
        .o_in_stall  (o_in_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    vdm_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ tb/tb_vector_distance_metric_unit_top.sv @@
// ----------------------------------------------------------------------------
// tb_vector_distance_metric_unit_top
// Self-checking bench for the vector distance metric unit.
// ----------------------------------------------------------------------------
// Vectors are streamed one coordinate pair per beat under each metric. A
// behavioral predictor tracks the running sums and computes the expected
// distance on every last pair. The predictor is fed from the beats that the
// block actually accepts. Output beats are compared in order. The phases vary
// the sender and receiver idling, and one phase holds the receiver off long
// enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vector_distance_metric_unit_top;
    import vdm_pkg::*;

    localparam int          MAX_PAIRS = MAX_ELEMS_DEFAULT;
    localparam logic [63:0] DIST_TOP  = (64'd1 << DIST_W) - 64'd1;
    localparam logic [63:0] UNITY     = 64'd65536;
    localparam int          STALL_LIMIT = 5000;
    localparam int          SETTLE_CYCLES = 250;

    // Idling modes of a phase.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_TX   = 1;
    localparam int IDLE_RX   = 2;
    localparam int IDLE_BOTH = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_vdm_in     i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_vdm_out    o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;

    vector_distance_metric_unit_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus waiting to be driven, and distances waiting to come out.
    t_vdm_in  pair_queue[$];
    t_vdm_out distance_queue[$];

    int       idle_mode = IDLE_NONE;
    logic     tx_hold = 1'b0;
    logic     rx_hold_req = 1'b0;
    int       rx_hold_left = 0;
    int       error_count = 0;
    int       quiet_cycles = 0;

    // Predictor state, mirroring the block's accumulators.
    t_metric         cur_metric = M_EUCLID;
    longint unsigned sq_diff_sum, a_sq_sum, b_sq_sum, peak_diff;
    longint          dot_sum;
    int unsigned     differ_cnt, nonzero_cnt, pairs_seen;

    task automatic clear_sums();
        sq_diff_sum = 0; a_sq_sum = 0; b_sq_sum = 0; peak_diff = 0;
        dot_sum = 0; differ_cnt = 0; nonzero_cnt = 0; pairs_seen = 0;
    endtask

    function automatic logic [63:0] wide_root(bit [127:0] v);
        logic [63:0] r;
        bit [127:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= v) begin
                r = c[63:0];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] fixed_of(longint unsigned x);
        if (x > (DIST_TOP >> 16)) begin
            return DIST_TOP;
        end
        return x << 16;
    endfunction

    // Folds one accepted pair into the sums. The saturation limits of the
    // accumulators cannot be reached with 1024 pairs of 16-bit values.
    task automatic take_pair(t_vdm_in p);
        longint          a, b, d;
        longint unsigned ad;
        a = p.coord_a;
        b = p.coord_b;
        if (pairs_seen < MAX_PAIRS) begin
            d = a - b;
            ad = (d < 0) ? -d : d;
            sq_diff_sum += (cur_metric == M_CITY) ? ad : ad * ad;
            if (ad > peak_diff) begin
                peak_diff = ad;
            end
            dot_sum += a * b;
            a_sq_sum += a * a;
            b_sq_sum += b * b;
            if (cur_metric == M_JACCARD) begin
                if (a != 0 || b != 0) nonzero_cnt++;
                if ((a != 0) != (b != 0)) differ_cnt++;
            end else if (a != b) begin
                differ_cnt++;
            end
            pairs_seen++;
        end else begin
            pairs_seen = MAX_PAIRS + 1;
        end
    endtask

    function automatic logic [63:0] distance_of();
        logic [63:0]     root, q;
        bit [127:0]      num;
        longint unsigned n, mag;
        n = (pairs_seen > MAX_PAIRS) ? MAX_PAIRS : pairs_seen;
        case (cur_metric)
            M_EUCLID: begin
                root = wide_root({64'd0, sq_diff_sum} << 32);
                return ((root >> 16) > (DIST_TOP >> 16)) ? DIST_TOP : root;
            end
            M_SQUARED, M_CITY: return fixed_of(sq_diff_sum);
            M_CHEBY:           return fixed_of(peak_diff);
            M_COSINE: begin
                // An all-zero vector makes the cosine undefined: distance 1.
                if (a_sq_sum == 0 || b_sq_sum == 0) begin
                    return UNITY;
                end
                root = wide_root(128'(a_sq_sum) * 128'(b_sq_sum));
                mag = (dot_sum < 0) ? -dot_sum : dot_sum;
                num = 128'(mag) * 128'(UNITY);
                if (root == 0 || num[127:64] >= root) begin
                    q = '1;
                end else begin
                    q = 64'(num / root);
                end
                if (q > UNITY) q = UNITY;
                return (dot_sum < 0) ? UNITY + q : UNITY - q;
            end
            M_HAMMING: return (n == 0) ? 64'd0 : (64'(differ_cnt) << 16) / n;
            // A vector pair with no nonzero coordinate is at distance 0.
            M_JACCARD: return (nonzero_cnt == 0) ? 64'd0
                              : (64'(differ_cnt) << 16) / nonzero_cnt;
            default:   return 64'd0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int tx_idle_pct();
        return (idle_mode == IDLE_TX) ? 76 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    endfunction

    // Driver: offers a pair whenever it is free and not idling, and feeds
    // the predictor with every accepted beat.
    always @(posedge i_clk) begin
        t_vdm_out res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                take_pair(i_in);
                if (i_in.last_pair) begin
                    res.distance = DIST_W'(distance_of());
                    res.length_overflow = (pairs_seen > MAX_PAIRS);
                    distance_queue = {distance_queue, res};
                    clear_sums();
                end
            end
            // A beat under stall stays on the bus unchanged.
            if (!i_in_valid || !o_in_stall) begin
                if (pair_queue.size() > 0 && !tx_hold &&
                    $urandom_range(99) >= tx_idle_pct()) begin
                    i_in <= pair_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off that lets the
    // block back up into its input.
    always @(posedge i_clk) begin
        int pct;
        pct = (idle_mode == IDLE_RX) ? 76 : (idle_mode == IDLE_BOTH) ? 13 : 0;
        if (rx_hold_req && rx_hold_left == 0) begin
            rx_hold_left <= 800;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
        i_out_stall <= (rx_hold_left > 1) || ($urandom_range(99) < pct);
    end

    // Monitor: every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_vdm_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (distance_queue.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(o_out.distance), 64'd0);
            end else begin
                want = distance_queue.pop_front();
                if (o_out.distance !== want.distance)
                    report_mismatch("distance", 64'(o_out.distance), 64'(want.distance));
                if (o_out.length_overflow !== want.length_overflow)
                    report_mismatch("length_overflow", 64'(o_out.length_overflow),
                                    64'(want.length_overflow));
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'(signed'($urandom_range(6)) - 3);
            2:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        t_vdm_in p;
        p.coord_a = a;
        p.coord_b = b;
        p.last_pair = last;
        pair_queue = {pair_queue, p};
    endtask

    // One random vector. The mix favors equal pairs and zeros so that the
    // Hamming, Jaccard and cosine corners come up often.
    task automatic add_vector(int len);
        logic signed [15:0] a, b;
        for (int i = 0; i < len; i++) begin
            a = pick_coord();
            b = pick_coord();
            case ($urandom_range(7))
                3: b = a;
                4: a = '0;
                5: b = '0;
                6: begin a = '0; b = '0; end
                default: ;
            endcase
            add_pair(a, b, i == len - 1);
        end
    endtask

    task automatic add_directed();
        add_pair(16'sh7fff, 16'sh8000, 1'b1);
        add_pair(16'sh0000, 16'sh0000, 1'b1);
        add_pair(16'sh8000, 16'sh8000, 1'b0);
        add_pair(16'sh0000, 16'sh0007, 1'b0);
        add_pair(16'sh0005, 16'sh0000, 1'b1);
        add_pair(-16'sd1, 16'sh0001, 1'b0);
        add_pair(16'sh0064, 16'sh0064, 1'b1);
    endtask

    task automatic add_random_vectors(int count);
        for (int v = 0; v < count; v++) begin
            add_vector(($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                : $urandom_range(1, 6));
        end
    endtask

    // Waits until every queued beat has gone in and every distance has come
    // out, then lets the block finish any vector still in flight.
    task automatic wait_idle();
        while (pair_queue.size() != 0 || i_in_valid || distance_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_metric(t_metric m);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_metric = m;
    endtask

    initial begin
        t_metric plan[16];
        plan = '{M_COSINE, M_JACCARD, M_EUCLID, M_SQUARED, M_CITY, M_CHEBY,
                 M_HAMMING, M_UNUSED, M_COSINE, M_EUCLID, M_JACCARD, M_HAMMING,
                 M_CITY, M_CHEBY, M_SQUARED, M_COSINE};
        clear_sums();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 16; ph++) begin
            wait_idle();
            write_metric(plan[ph]);
            idle_mode = ph % 4;
            if (ph < 3) add_directed();
            if (ph == 6) begin
                // Too many pairs: only the first 1024 count, overflow flagged.
                idle_mode = IDLE_NONE;
                add_vector(MAX_PAIRS + 1);
            end
            if (ph == 4) begin
                // Keep the sender busy while the receiver holds off.
                idle_mode = IDLE_NONE;
                add_random_vectors(4);
                @(posedge i_clk);
                rx_hold_req <= 1'b1;
                @(posedge i_clk);
                rx_hold_req <= 1'b0;
            end
            add_random_vectors(1);
            // The sender pauses until every pending distance is out.
            while (pair_queue.size() != 0) @(posedge i_clk);
            tx_hold <= 1'b1;
            while (i_in_valid || distance_queue.size() != 0) @(posedge i_clk);
            tx_hold <= 1'b0;
        end

        wait_idle();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ vector_distance_metric_unit_top.f @@
hw/rtl/vdm_pkg.sv
hw/rtl/vdm_isqrt.sv
hw/rtl/vdm_div.sv
hw/rtl/vdm_datapath.sv
hw/rtl/vdm_ctrl.sv
hw/rtl/vector_distance_metric_unit_top.sv
tb/tb_vector_distance_metric_unit_top.sv
